FILE: rtl/core/utc_timestamp_to_epoch_seconds_assert.svh
// assertion macros shared by the timestamp converter modules
`ifndef UTC_TIMESTAMP_TO_EPOCH_SECONDS_ASSERT_SVH
`define UTC_TIMESTAMP_TO_EPOCH_SECONDS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define UTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ute same-cycle check failed");

// next-cycle implication, disabled in reset
`define UTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ute next-cycle check failed");

`endif

FILE: rtl/core/ute_pkg.sv
// shared types, constants and helper functions of the timestamp converter
package ute_pkg;

   localparam int CH_W    = 8;
   localparam int EPOCH_W = 38;
   localparam int YEAR_W  = 14;
   localparam int FIELD_W = 7;
   localparam int POS_W   = 5;

   // string layout
   localparam logic [POS_W-1:0] POS_DASH1  = 5'd4;
   localparam logic [POS_W-1:0] POS_DASH2  = 5'd7;
   localparam logic [POS_W-1:0] POS_T      = 5'd10;
   localparam logic [POS_W-1:0] POS_COLON1 = 5'd13;
   localparam logic [POS_W-1:0] POS_COLON2 = 5'd16;
   localparam logic [POS_W-1:0] POS_Z      = 5'd19;
   localparam logic [POS_W-1:0] STAMP_LEN  = 5'd20;
   localparam logic [POS_W-1:0] POS_HOLD   = 5'd21;

   localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CH_W-1:0] CHAR_T     = 8'h54;
   localparam logic [CH_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CH_W-1:0] CHAR_Z     = 8'h5A;

   // range limits
   localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1970;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
   localparam logic [FIELD_W-1:0] DAY_MAX    = 7'd31;
   localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
   localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX  = 38'd253402300799;

   // day count arithmetic
   localparam int                 DAYS_W      = 24;
   localparam logic [DAYS_W-1:0]  LEAP_BIAS   = 24'd477;
   localparam logic [8:0]         DAYS_YEAR   = 9'd365;
   // x / 100 == (x * 5243) >> 19 for every 14-bit x
   localparam int                 RECIP_SHIFT = 19;
   localparam logic [12:0]        RECIP_100   = 13'd5243;
   localparam int                 QUOT_W      = 8;
   localparam logic [6:0]         HUNDRED     = 7'd100;

   // queue between parser and converter
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic               bad;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } qpush_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SPLIT = 8'b0000_0010,
      ST_YEAR  = 8'b0000_0100,
      ST_DAYS  = 8'b0000_1000,
      ST_HOUR  = 8'b0001_0000,
      ST_MIN   = 8'b0010_0000,
      ST_SEC   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } back_state_type;

   // acc * 10 + d, kept to the year width
   function automatic logic [YEAR_W-1:0] push_year(logic [YEAR_W-1:0] acc, logic [3:0] d);
      logic [YEAR_W+2:0] sum;
      sum = {acc, 3'b000} + (YEAR_W+3)'({acc, 1'b0}) + (YEAR_W+3)'(d);
      return sum[YEAR_W-1:0];
   endfunction

   // acc * 10 + d, kept to the field width
   function automatic logic [FIELD_W-1:0] push_field(logic [FIELD_W-1:0] acc, logic [3:0] d);
      logic [FIELD_W+2:0] sum;
      sum = {acc, 3'b000} + (FIELD_W+3)'({acc, 1'b0}) + (FIELD_W+3)'(d);
      return sum[FIELD_W-1:0];
   endfunction

   // days before the first of each month in a common year
   function automatic logic [8:0] month_start(logic [3:0] idx);
      logic [8:0] days;
      case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

FILE: rtl/core/ute_channels.sv
// valid/ready channel interfaces for characters in and epoch results out
interface ute_req_if;
   logic                      valid;
   logic                      ready;
   logic [ute_pkg::CH_W-1:0]  ch;
   logic                      last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ute_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ute_pkg::EPOCH_W-1:0]  epoch_seconds;
   logic                         ok;

   modport source (output valid, output epoch_seconds, output ok, input ready);
   modport sink   (input valid, input epoch_seconds, input ok, output ready);
endinterface

FILE: rtl/core/ute_queue.sv
// two-entry queue of parsed timestamps between parser and converter
`include "utc_timestamp_to_epoch_seconds_assert.svh"

module ute_queue (
   input  logic               clock,
   input  logic               reset,
   input  ute_pkg::qpush_type push,
   input  logic               pop,
   output ute_pkg::qstat_type stat,
   output ute_pkg::rec_type   head
);

   ute_pkg::rec_type                 entry_ff [ute_pkg::QUEUE_DEPTH];
   logic [ute_pkg::QIDX_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ute_pkg::QIDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ute_pkg::QCNT_W-1:0]       count_ff, count_in;

   // status and head entry
   assign stat.full  = (count_ff == ute_pkg::QCNT_W'(ute_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == ute_pkg::QIDX_W'(ute_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ute_pkg::QIDX_W'(ute_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.rec;
      end
   end

   `UTE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= ute_pkg::QCNT_W'(ute_pkg::QUEUE_DEPTH))
   `UTE_ASSERT_NOW(a_no_overflow, clock, reset, push.valid && stat.full, pop)
   `UTE_ASSERT_NOW(a_no_underflow, clock, reset, pop, !stat.empty)

endmodule

FILE: rtl/core/ute_front.sv
// character parser: checks each beat against its position and builds the fields
`include "utc_timestamp_to_epoch_seconds_assert.svh"

module ute_front (
   input  logic               clock,
   input  logic               reset,
   ute_req_if.sink            req_bus,
   input  ute_pkg::qstat_type q_stat,
   output ute_pkg::qpush_type q_push
);

   logic [ute_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [ute_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [ute_pkg::FIELD_W-1:0] month_ff, month_in;
   logic [ute_pkg::FIELD_W-1:0] day_ff, day_in;
   logic [ute_pkg::FIELD_W-1:0] hour_ff, hour_in;
   logic [ute_pkg::FIELD_W-1:0] minute_ff, minute_in;
   logic [ute_pkg::FIELD_W-1:0] second_ff, second_in;
   logic                        fmt_err_ff, fmt_err_in;
   logic                        accept;
   logic                        is_digit;
   logic [3:0]                  digit_val;
   logic                        has_sep;
   logic [ute_pkg::CH_W-1:0]    sep_char;

   // take beats whenever the queue has room
   assign req_bus.ready = !q_stat.full;
   assign accept        = req_bus.valid && req_bus.ready;

   assign is_digit  = (req_bus.ch >= ute_pkg::CHAR_ZERO) && (req_bus.ch <= ute_pkg::CHAR_NINE);
   assign digit_val = is_digit ? req_bus.ch[3:0] : 4'd0;

   // separator expected at this position
   always_comb begin
      has_sep  = 1'b0;
      sep_char = '0;
      unique case (pos_ff) inside
         ute_pkg::POS_DASH1, ute_pkg::POS_DASH2: begin
            has_sep  = 1'b1;
            sep_char = ute_pkg::CHAR_DASH;
         end
         ute_pkg::POS_T: begin
            has_sep  = 1'b1;
            sep_char = ute_pkg::CHAR_T;
         end
         ute_pkg::POS_COLON1, ute_pkg::POS_COLON2: begin
            has_sep  = 1'b1;
            sep_char = ute_pkg::CHAR_COLON;
         end
         ute_pkg::POS_Z: begin
            has_sep  = 1'b1;
            sep_char = ute_pkg::CHAR_Z;
         end
         default: begin
            has_sep  = 1'b0;
            sep_char = '0;
         end
      endcase
   end

   // digit accumulation and format check
   always_comb begin
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      fmt_err_in = fmt_err_ff;
      if (pos_ff < ute_pkg::STAMP_LEN) begin
         if (has_sep) begin
            if (req_bus.ch != sep_char) fmt_err_in = 1'b1;
         end else if (!is_digit) begin
            fmt_err_in = 1'b1;
         end else if (pos_ff < ute_pkg::POS_DASH1) begin
            year_in = ute_pkg::push_year(year_ff, digit_val);
         end else if (pos_ff < ute_pkg::POS_DASH2) begin
            month_in = ute_pkg::push_field(month_ff, digit_val);
         end else if (pos_ff < ute_pkg::POS_T) begin
            day_in = ute_pkg::push_field(day_ff, digit_val);
         end else if (pos_ff < ute_pkg::POS_COLON1) begin
            hour_in = ute_pkg::push_field(hour_ff, digit_val);
         end else if (pos_ff < ute_pkg::POS_COLON2) begin
            minute_in = ute_pkg::push_field(minute_ff, digit_val);
         end else begin
            second_in = ute_pkg::push_field(second_ff, digit_val);
         end
      end else begin
         fmt_err_in = 1'b1;
      end
      pos_in = (pos_ff < ute_pkg::POS_HOLD) ? pos_ff + 1'b1 : pos_ff;
   end

   // hand the finished string to the converter on the end beat
   always_comb begin
      q_push.valid      = accept && req_bus.last;
      q_push.rec.year   = year_in;
      q_push.rec.month  = month_in;
      q_push.rec.day    = day_in;
      q_push.rec.hour   = hour_in;
      q_push.rec.minute = minute_in;
      q_push.rec.second = second_in;
      q_push.rec.bad    = fmt_err_in || (pos_in != ute_pkg::STAMP_LEN);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_bus.last)) begin
         pos_ff     <= '0;
         year_ff    <= '0;
         month_ff   <= '0;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         fmt_err_ff <= 1'b0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         fmt_err_ff <= fmt_err_in;
      end
   end

   `UTE_ASSERT_NOW(a_pos_saturates, clock, reset, 1'b1, pos_ff <= ute_pkg::POS_HOLD)
   `UTE_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_bus.last, pos_ff == '0 && !fmt_err_ff)
   `UTE_ASSERT_NOW(a_late_is_error, clock, reset, pos_ff > ute_pkg::STAMP_LEN, fmt_err_ff)

endmodule

FILE: rtl/core/ute_back.sv
// converter: range checks a parsed timestamp and works out epoch seconds in steps
`include "utc_timestamp_to_epoch_seconds_assert.svh"

module ute_back (
   input  logic               clock,
   input  logic               reset,
   input  ute_pkg::qstat_type q_stat,
   input  ute_pkg::rec_type   q_head,
   output logic               q_pop,
   ute_rsp_if.source          rsp_bus
);

   ute_pkg::back_state_type        state_ff, state_in;
   ute_pkg::rec_type               rec_ff;
   logic [ute_pkg::QUOT_W-1:0]     qx_ff, qy_ff;
   logic                           range_ok_ff, ok_ff, leap_ff;
   logic [ute_pkg::EPOCH_W-1:0]    acc_ff;
   logic [ute_pkg::EPOCH_W-1:0]    epoch_ff;
   logic                           rsp_ok_ff;

   logic [ute_pkg::YEAR_W-1:0]     year_m1;
   logic [ute_pkg::YEAR_W+12:0]    prod_x, prod_y;
   logic                           range_ok;
   logic [ute_pkg::YEAR_W-1:0]     rem_y;
   logic                           leap;
   logic [ute_pkg::FIELD_W-1:0]    mdays;
   logic [ute_pkg::DAYS_W-1:0]     year_days;
   logic [ute_pkg::DAYS_W-1:0]     day_sum;
   logic [ute_pkg::EPOCH_W-1:0]    hour_sum, min_sum, sec_sum;

   assign q_pop = (state_ff == ute_pkg::ST_IDLE) && !q_stat.empty;

   // quotients by 100 of year and year - 1 through a reciprocal
   assign year_m1 = rec_ff.year - 1'b1;
   assign prod_x  = year_m1 * ute_pkg::RECIP_100;
   assign prod_y  = rec_ff.year * ute_pkg::RECIP_100;

   assign range_ok = !rec_ff.bad
                  && (rec_ff.year >= ute_pkg::YEAR_MIN) && (rec_ff.year <= ute_pkg::YEAR_MAX)
                  && (rec_ff.month != '0) && (rec_ff.month <= ute_pkg::MONTH_MAX)
                  && (rec_ff.day != '0) && (rec_ff.day <= ute_pkg::DAY_MAX)
                  && (rec_ff.hour <= ute_pkg::HOUR_MAX)
                  && (rec_ff.minute <= ute_pkg::MINSEC_MAX)
                  && (rec_ff.second <= ute_pkg::MINSEC_MAX);

   // leap year and month length
   assign rem_y = rec_ff.year
                - (ute_pkg::YEAR_W'(qy_ff) * ute_pkg::YEAR_W'(ute_pkg::HUNDRED));
   assign leap  = (rec_ff.year[1:0] == 2'b00) && ((rem_y != '0) || (qy_ff[1:0] == 2'b00));

   always_comb begin
      unique case (rec_ff.month) inside
         7'd2:                    mdays = leap ? 7'd29 : 7'd28;
         7'd4, 7'd6, 7'd9, 7'd11: mdays = 7'd30;
         default:                 mdays = 7'd31;
      endcase
   end

   // whole days before January 1 of this year
   assign year_days = ute_pkg::DAYS_W'(rec_ff.year - ute_pkg::YEAR_MIN)
                      * ute_pkg::DAYS_W'(ute_pkg::DAYS_YEAR)
                    + ute_pkg::DAYS_W'(year_m1[ute_pkg::YEAR_W-1:2])
                    - ute_pkg::DAYS_W'(qx_ff)
                    + ute_pkg::DAYS_W'(qx_ff[ute_pkg::QUOT_W-1:2])
                    - ute_pkg::LEAP_BIAS;

   // plus days before this date within the year
   assign day_sum = acc_ff[ute_pkg::DAYS_W-1:0]
                  + ute_pkg::DAYS_W'(ute_pkg::month_start(rec_ff.month[3:0] - 4'd1))
                  + ute_pkg::DAYS_W'(rec_ff.day) - 1'b1
                  + ute_pkg::DAYS_W'((rec_ff.month > 7'd2) && leap_ff);

   assign hour_sum = ute_pkg::EPOCH_W'(acc_ff * 5'd24) + ute_pkg::EPOCH_W'(rec_ff.hour);
   assign min_sum  = ute_pkg::EPOCH_W'(acc_ff * 6'd60) + ute_pkg::EPOCH_W'(rec_ff.minute);
   assign sec_sum  = ute_pkg::EPOCH_W'(acc_ff * 6'd60) + ute_pkg::EPOCH_W'(rec_ff.second);

   // step sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ute_pkg::ST_IDLE:  if (!q_stat.empty) state_in = ute_pkg::ST_SPLIT;
         ute_pkg::ST_SPLIT: state_in = ute_pkg::ST_YEAR;
         ute_pkg::ST_YEAR:  state_in = ute_pkg::ST_DAYS;
         ute_pkg::ST_DAYS:  state_in = ute_pkg::ST_HOUR;
         ute_pkg::ST_HOUR:  state_in = ute_pkg::ST_MIN;
         ute_pkg::ST_MIN:   state_in = ute_pkg::ST_SEC;
         ute_pkg::ST_SEC:   state_in = ute_pkg::ST_DONE;
         ute_pkg::ST_DONE:  if (rsp_bus.ready) state_in = ute_pkg::ST_IDLE;
         default:           state_in = ute_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ute_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers for each step
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff <= q_head;
      end
      if (state_ff == ute_pkg::ST_SPLIT) begin
         qx_ff       <= prod_x[ute_pkg::RECIP_SHIFT +: ute_pkg::QUOT_W];
         qy_ff       <= prod_y[ute_pkg::RECIP_SHIFT +: ute_pkg::QUOT_W];
         range_ok_ff <= range_ok;
      end
      if (state_ff == ute_pkg::ST_YEAR) begin
         leap_ff <= leap;
         ok_ff   <= range_ok_ff && (rec_ff.day <= mdays);
         acc_ff  <= ute_pkg::EPOCH_W'(year_days);
      end
      if (state_ff == ute_pkg::ST_DAYS) begin
         acc_ff <= ute_pkg::EPOCH_W'(day_sum);
      end
      if (state_ff == ute_pkg::ST_HOUR) begin
         acc_ff <= hour_sum;
      end
      if (state_ff == ute_pkg::ST_MIN) begin
         acc_ff <= min_sum;
      end
      if (state_ff == ute_pkg::ST_SEC) begin
         epoch_ff  <= ok_ff ? sec_sum : '0;
         rsp_ok_ff <= ok_ff;
      end
   end

   // result beat
   assign rsp_bus.valid         = (state_ff == ute_pkg::ST_DONE);
   assign rsp_bus.epoch_seconds = epoch_ff;
   assign rsp_bus.ok            = rsp_ok_ff;

   `UTE_ASSERT_NOW(a_bad_is_zero, clock, reset, rsp_bus.valid && !rsp_bus.ok, rsp_bus.epoch_seconds == '0)
   `UTE_ASSERT_NOW(a_good_in_range, clock, reset, rsp_bus.valid && rsp_bus.ok, rsp_bus.epoch_seconds <= ute_pkg::EPOCH_MAX)
   `UTE_ASSERT_NEXT(a_done_to_idle, clock, reset, rsp_bus.valid && rsp_bus.ready, state_ff == ute_pkg::ST_IDLE)

endmodule

FILE: rtl/core/utc_timestamp_to_epoch_seconds.sv
// Timestamp string to epoch seconds, top level.
// The end-marked string passes through the queue and the converter states SPLIT, YEAR,
// DAYS, HOUR, MIN and SEC; its result beat is then valid in DONE until the receiver takes it.
// Throughput: one character per cycle while the 2-entry queue has room; strings convert in turn.
// Reset (synchronous, active high) empties the queue, idles the converter and clears the parser.
module utc_timestamp_to_epoch_seconds (
   input logic         clock,
   input logic         reset,
   ute_req_if.sink     req_bus,
   ute_rsp_if.source   rsp_bus
);

   ute_pkg::qpush_type q_push;
   ute_pkg::qstat_type q_stat;
   ute_pkg::rec_type   q_head;
   logic               q_pop;

   // parser
   ute_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_stat  (q_stat),
      .q_push  (q_push)
   );

   // queue of parsed strings
   ute_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .stat  (q_stat),
      .head  (q_head)
   );

   // converter
   ute_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

FILE: tb/tb.sv
// testbench for the timestamp string to epoch seconds converter
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ute_pkg::*;

   localparam int LATENCY      = 7;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 2000;

   typedef logic [CH_W-1:0] stamp_bytes_t [$];

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch_seconds;
      logic               ok;
   } epoch_result_t;

   typedef enum logic [1:0] {
      RDY_OPEN,
      RDY_COIN,
      RDY_SPARSE,
      RDY_LONG
   } ready_mode_t;

   logic clock;
   logic reset;

   ute_req_if req_if ();
   ute_rsp_if rsp_if ();

   utc_timestamp_to_epoch_seconds dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // predicted parser state
   logic [POS_W-1:0]   pos_count     = '0;
   logic [YEAR_W-1:0]  year_digits   = '0;
   logic [FIELD_W-1:0] month_digits  = '0;
   logic [FIELD_W-1:0] day_digits    = '0;
   logic [FIELD_W-1:0] hour_digits   = '0;
   logic [FIELD_W-1:0] minute_digits = '0;
   logic [FIELD_W-1:0] second_digits = '0;
   logic               bad_byte_seen = 1'b0;

   int unsigned days_before_month [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   epoch_result_t pending_epochs [$];
   int            error_count = 0;
   int            beats_sent  = 0;
   int            burst_left  = 0;
   int            cycle_count = 0;

   ready_mode_t ready_mode  = RDY_OPEN;
   int          mode_left   = 0;
   int unsigned ready_phase = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // one line per mismatch
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Gregorian month length
   function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
      logic leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
         2:          return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   // range check and conversion of the collected fields
   function automatic epoch_result_t epoch_from_fields();
      epoch_result_t   r;
      int unsigned     y;
      int unsigned     m;
      int unsigned     d;
      longint unsigned days;
      longint unsigned secs;
      r.epoch_seconds = '0;
      r.ok = 1'b0;
      y = year_digits;
      m = month_digits;
      d = day_digits;
      if (bad_byte_seen || pos_count != STAMP_LEN) return r;
      if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > MONTH_MAX || d < 1 ||
          hour_digits > HOUR_MAX || minute_digits > MINSEC_MAX || second_digits > MINSEC_MAX)
         return r;
      if (d > month_length(y, m)) return r;
      days = 64'(y - YEAR_MIN) * 365 + 64'((y - 1) / 4) - 64'((y - 1) / 100)
             + 64'((y - 1) / 400) - 64'(LEAP_BIAS);
      days += days_before_month[m - 1] + d - 1;
      if (m > 2 && month_length(y, 2) == 29) days += 1;
      secs = ((days * 24 + hour_digits) * 60 + minute_digits) * 60 + second_digits;
      r.epoch_seconds = secs[EPOCH_W-1:0];
      r.ok = 1'b1;
      return r;
   endfunction

   // advance the predicted parser by one accepted character
   task automatic decode_stamp_char(input logic [CH_W-1:0] c, input logic l);
      logic            is_digit;
      logic            is_sep;
      logic [CH_W-1:0] sep_char;
      logic [3:0]      dv;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      dv = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
      is_sep = 1'b0;
      sep_char = '0;
      case (pos_count)
         POS_DASH1, POS_DASH2: begin
            is_sep = 1'b1;
            sep_char = CHAR_DASH;
         end
         POS_T: begin
            is_sep = 1'b1;
            sep_char = CHAR_T;
         end
         POS_COLON1, POS_COLON2: begin
            is_sep = 1'b1;
            sep_char = CHAR_COLON;
         end
         POS_Z: begin
            is_sep = 1'b1;
            sep_char = CHAR_Z;
         end
         default: is_sep = 1'b0;
      endcase
      if (pos_count < STAMP_LEN) begin
         if (is_sep) begin
            if (c != sep_char) bad_byte_seen = 1'b1;
         end else if (!is_digit) begin
            bad_byte_seen = 1'b1;
         end else if (pos_count < POS_DASH1) begin
            year_digits = year_digits * 14'd10 + YEAR_W'(dv);
         end else if (pos_count < POS_DASH2) begin
            month_digits = month_digits * 7'd10 + FIELD_W'(dv);
         end else if (pos_count < POS_T) begin
            day_digits = day_digits * 7'd10 + FIELD_W'(dv);
         end else if (pos_count < POS_COLON1) begin
            hour_digits = hour_digits * 7'd10 + FIELD_W'(dv);
         end else if (pos_count < POS_COLON2) begin
            minute_digits = minute_digits * 7'd10 + FIELD_W'(dv);
         end else begin
            second_digits = second_digits * 7'd10 + FIELD_W'(dv);
         end
      end else begin
         bad_byte_seen = 1'b1;
      end
      // position saturates past the stamp length
      if (pos_count < POS_HOLD) pos_count = pos_count + 1'b1;
      if (l) begin
         pending_epochs.push_back(epoch_from_fields());
         pos_count     = '0;
         year_digits   = '0;
         month_digits  = '0;
         day_digits    = '0;
         hour_digits   = '0;
         minute_digits = '0;
         second_digits = '0;
         bad_byte_seen = 1'b0;
      end
   endtask

   // drive one character beat, then maybe open a gap
   task automatic send_beat(input logic [CH_W-1:0] c, input logic l);
      req_if.valid <= 1'b1;
      req_if.ch    <= c;
      req_if.last  <= l;
      do @(posedge clock); while (!req_if.ready);
      decode_stamp_char(c, l);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(0, 12);
      end
   endtask

   task automatic send_stamp(input stamp_bytes_t s);
      foreach (s[i]) send_beat(s[i], i == s.size() - 1);
   endtask

   function automatic stamp_bytes_t text_to_bytes(input string s);
      stamp_bytes_t q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   task automatic send_text(input string s);
      send_stamp(text_to_bytes(s));
   endtask

   // hold the sender until every pending result has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_epochs.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   function automatic stamp_bytes_t make_valid_stamp();
      int unsigned y;
      int unsigned m;
      case ($urandom_range(0, 7))
         0:       y = YEAR_MIN;
         1:       y = YEAR_MAX;
         2:       y = 400 * $urandom_range(5, 24);
         3:       y = 100 * $urandom_range(20, 99);
         default: y = $urandom_range(YEAR_MIN, YEAR_MAX);
      endcase
      m = $urandom_range(1, 12);
      return text_to_bytes($sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", y, m,
         $urandom_range(1, month_length(y, m)), $urandom_range(0, 23),
         $urandom_range(0, 59), $urandom_range(0, 59)));
   endfunction

   // well-formed digits, values around and past the limits
   function automatic stamp_bytes_t make_range_stamp();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned h;
      int unsigned mi;
      int unsigned s;
      case ($urandom_range(0, 2))
         0:       y = $urandom_range(1965, 1975);
         1:       y = $urandom_range(9990, 9999);
         default: y = $urandom_range(0, 9999);
      endcase
      m  = $urandom_range(0, 1) ? $urandom_range(0, 14) : $urandom_range(0, 99);
      d  = $urandom_range(0, 1) ? $urandom_range(27, 33) : $urandom_range(0, 99);
      h  = $urandom_range(0, 1) ? $urandom_range(20, 25) : $urandom_range(0, 99);
      mi = $urandom_range(0, 1) ? $urandom_range(57, 61) : $urandom_range(0, 99);
      s  = $urandom_range(0, 1) ? $urandom_range(57, 61) : $urandom_range(0, 99);
      return text_to_bytes($sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", y, m, d, h, mi, s));
   endfunction

   function automatic logic [CH_W-1:0] pick_odd_byte();
      case ($urandom_range(0, 7))
         0:       return CHAR_DASH;
         1:       return CHAR_T;
         2:       return CHAR_COLON;
         3:       return CHAR_Z;
         4:       return CHAR_ZERO + CH_W'($urandom_range(0, 9));
         5:       return CHAR_ZERO - 1'b1;
         6:       return CHAR_NINE + 1'b1;
         default: return CH_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_boundary_stamps();
      send_text("1970-01-01T00:00:00Z");
      send_text("9999-12-31T23:59:59Z");
      send_text("1969-12-31T23:59:59Z");
      send_text("0000-01-01T00:00:00Z");
      send_text("2038-01-19T03:14:08Z");
   endtask

   task automatic test_calendar_rules();
      // leap years: every fourth, not centuries, except every fourth century
      send_text("2000-02-29T12:34:56Z");
      send_text("2100-02-29T00:00:00Z");
      send_text("2024-02-29T23:59:59Z");
      send_text("2023-02-29T00:00:00Z");
      send_text("2024-03-01T00:00:00Z");
      send_text("2021-04-31T00:00:00Z");
      send_text("2021-00-10T00:00:00Z");
      send_text("2021-13-10T00:00:00Z");
      send_text("2021-01-00T00:00:00Z");
      send_text("2021-01-32T00:00:00Z");
      send_text("2021-06-15T24:00:00Z");
      send_text("2021-06-15T23:60:00Z");
      send_text("2021-06-15T23:59:60Z");
   endtask

   task automatic test_format_errors();
      stamp_bytes_t s;
      send_text("2021/06-15T12:00:00Z");
      send_text("2021-06-15 12:00:00Z");
      send_text("2021-06-15T12:00:00z");
      send_text("2021-06-1/T12:00:00Z");
      send_text("2021-06-1:T12:00:00Z");
      // zero byte in place of a separator
      s = text_to_bytes("2021-06-15T12:00:00Z");
      s[POS_T] = 8'h00;
      send_stamp(s);
      // digit with the top bit set, and an all-ones byte
      s = text_to_bytes("2021-06-15T12:00:00Z");
      s[2] = 8'hB0;
      s[15] = 8'hFF;
      send_stamp(s);
   endtask

   task automatic test_length_errors();
      send_text("2021-06-15T12:00:00");
      send_text("Z");
      send_text("2021-06-15T12:00:00ZZ");
      // long enough that a wrapping position counter would show
      send_text({"2021-06-15T12:00:00Z", "2021-06-15T12:00:00Z", "2021-06-15T12:00:00Z"});
   endtask

   task automatic test_random_mix();
      stamp_bytes_t s;
      int           kind;
      int           n;
      logic         paused;
      paused = 1'b0;
      while (beats_sent < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            s = make_valid_stamp();
         end else if (kind < 70) begin
            s = make_range_stamp();
         end else if (kind < 82) begin
            s = make_valid_stamp();
            s[$urandom_range(0, STAMP_LEN - 1)] = pick_odd_byte();
         end else if (kind < 88) begin
            s = make_valid_stamp();
            repeat ($urandom_range(1, 19)) void'(s.pop_back());
         end else if (kind < 93) begin
            s = make_valid_stamp();
            repeat ($urandom_range(1, 25)) s.push_back(pick_odd_byte());
         end else begin
            s.delete();
            n = $urandom_range(1, 45);
            repeat (n) s.push_back(CH_W'($urandom_range(0, 255)));
         end
         send_stamp(s);
         if (!paused && beats_sent >= RANDOM_BEATS / 2) begin
            paused = 1'b1;
            drain_results();
         end
      end
   endtask

   // receiver stall pattern, switching among four ready modes chosen at random
   initial begin : result_receiver
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         ready_phase++;
         case (ready_mode)
            RDY_OPEN:   rsp_if.ready <= 1'b1;
            RDY_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_if.ready <= (ready_phase % 24 == 0);
         endcase
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : result_checker
      epoch_result_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_epochs.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_if.epoch_seconds, 0);
         end else begin
            want = pending_epochs.pop_front();
            if (rsp_if.epoch_seconds !== want.epoch_seconds)
               report_mismatch("epoch_seconds", rsp_if.epoch_seconds, want.epoch_seconds);
            if (rsp_if.ok !== want.ok)
               report_mismatch("ok", rsp_if.ok, want.ok);
         end
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("utc_timestamp_to_epoch_seconds test failed");
      $finish;
   end

   // test sequence
   initial begin : test_sequence
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.ch    <= '0;
      req_if.last  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_boundary_stamps();
      test_calendar_rules();
      test_format_errors();
      test_length_errors();
      drain_results();
      test_random_mix();
      drain_results();
      if (error_count == 0 && pending_epochs.size() == 0) begin
         $display("utc_timestamp_to_epoch_seconds test passed");
      end else begin
         $display("utc_timestamp_to_epoch_seconds test failed");
      end
      $finish;
   end

endmodule

FILE: utc_timestamp_to_epoch_seconds.f
+incdir+rtl/core
rtl/core/ute_pkg.sv
rtl/core/ute_channels.sv
rtl/core/ute_queue.sv
rtl/core/ute_front.sv
rtl/core/ute_back.sv
rtl/core/utc_timestamp_to_epoch_seconds.sv
tb/tb.sv
